FILE: hdl/assert_macros.svh
// Assertion helpers for the queue RTL.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define TCPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication: cons must hold in the cycle after ante.
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define TCPQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

   localparam int DEPTH    = 128;
   localparam int KEY_BITS = 16;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int OCC_BITS = 8;
   localparam int OP_BITS  = 2;
   localparam int STS_BITS = 2;

   localparam int REQ_TDATA_BITS = ((KEY_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_BITS = OP_BITS + 1;
   localparam int RSP_TDATA_BITS = ((KEY_BITS + OCC_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_BITS = STS_BITS + 1;

   localparam logic [OP_BITS-1:0] OP_ADD     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_PROMOTE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SERVE   = 2'd2;

   localparam logic [STS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STS_BITS-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STS_BITS-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [STS_BITS-1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic                urg;
   } entry_type;

   // Seek: look for the insertion slot. Shift: carry a displaced entry.
   // Search: look for a key. Pass: work done, ride out to the tail.
   typedef enum logic [1:0] {
      WAVE_SEEK,
      WAVE_SHIFT,
      WAVE_SEARCH,
      WAVE_PASS
   } wave_mode_type;

   typedef struct packed {
      logic          act;
      wave_mode_type mode;
      entry_type     ent;
   } fwd_type;

   typedef struct packed {
      logic      act;
      entry_type ent;
   } bw_type;

   typedef struct packed {
      logic    shift_up;
      fwd_type fwd;
   } chain_ctl_type;

   typedef struct packed {
      logic      pull_done;
      fwd_type   tail_fwd;
      entry_type head_ent;
   } chain_sts_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_WAVE,
      CTL_PULL,
      CTL_POST
   } ctl_state_type;

endpackage

FILE: hdl/two_class_priority_queue_promote_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Dir  Beat fields (tdata / tuser, lowest bit first)
// req_     in   tdata: key[15:0]            tuser: operation[1:0], urgent[2]
// rsp_     out  tdata: served_key[15:0], occupancy[23:16]
//                                           tuser: status[1:0], served_urgent[2]
//
// One request is in flight at a time; req_tready is high only when idle.
// Serve, add to a full queue, unused code: straight to POST, then the registered beat.
// Add, and promote of a missing key: the response waits for the tailward wave to
// cross every slot.
// Promote of the slot at index k: the response waits for the tailward search wave
// and the headward pull back to slot 0.
// Reset is synchronous; it clears control and the count, no clearing pass.
// A stalled response holds in the output register; the queue waits in POST.
module two_class_priority_queue_promote_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key[15:0]
   input  logic [tcpq_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // operation[1:0], urgent[2]
   input  logic [tcpq_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // served_key[15:0], occupancy[23:16]
   output logic [tcpq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // status[1:0], served_urgent[2]
   output logic [tcpq_pkg::RSP_TUSER_BITS-1:0] rsp_tuser
);

   tcpq_pkg::ctl_state_type state_ff, state_in;
   logic [tcpq_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [tcpq_pkg::OP_BITS-1:0]  op_ff, op_in;
   tcpq_pkg::fwd_type             wave_ff, wave_in;
   logic                          pull_seen_ff, pull_seen_in;
   logic [tcpq_pkg::STS_BITS-1:0] res_status_ff, res_status_in;
   logic [tcpq_pkg::KEY_BITS-1:0] res_key_ff, res_key_in;
   logic                          res_urg_ff, res_urg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tcpq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [tcpq_pkg::RSP_TUSER_BITS-1:0] rsp_tuser_ff, rsp_tuser_in;

   tcpq_pkg::chain_ctl_type ctl;
   tcpq_pkg::chain_sts_type sts;

   logic [tcpq_pkg::OP_BITS-1:0]  req_op;
   logic [tcpq_pkg::KEY_BITS-1:0] req_key;
   logic                          req_urg;
   logic                          accept;
   logic                          full;
   logic                          empty;
   logic                          post_ok;
   logic                          pull_hit;

   // Unpack the request beat.
   assign req_op  = req_tuser[tcpq_pkg::OP_BITS-1:0];
   assign req_urg = req_tuser[tcpq_pkg::OP_BITS];
   assign req_key = req_tdata[tcpq_pkg::KEY_BITS-1:0];

   assign req_tready = (state_ff == tcpq_pkg::CTL_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == tcpq_pkg::CNT_BITS'(tcpq_pkg::DEPTH));
   assign empty      = (count_ff == '0);
   assign post_ok    = !rsp_valid_ff || rsp_tready;
   // the headward pull may land before or with the search wave's exit
   assign pull_hit   = pull_seen_ff || sts.pull_done;

   tcpq_chain u_chain (
      .clock (clock),
      .reset (reset),
      .count (count_ff),
      .ctl   (ctl),
      .sts   (sts)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcpq_pkg::CTL_IDLE: begin
            if (accept) begin
               if (((req_op == tcpq_pkg::OP_ADD) && !full) ||
                   (req_op == tcpq_pkg::OP_PROMOTE)) begin
                  state_in = tcpq_pkg::CTL_WAVE;
               end else begin
                  state_in = tcpq_pkg::CTL_POST;
               end
            end
         end
         tcpq_pkg::CTL_WAVE: begin
            if (sts.tail_fwd.act) begin
               if ((op_ff == tcpq_pkg::OP_PROMOTE) &&
                   (sts.tail_fwd.mode == tcpq_pkg::WAVE_PASS) && !pull_hit) begin
                  state_in = tcpq_pkg::CTL_PULL;
               end else begin
                  state_in = tcpq_pkg::CTL_POST;
               end
            end
         end
         tcpq_pkg::CTL_PULL: begin
            if (sts.pull_done) begin
               state_in = tcpq_pkg::CTL_POST;
            end
         end
         tcpq_pkg::CTL_POST: begin
            if (post_ok) begin
               state_in = tcpq_pkg::CTL_IDLE;
            end
         end
      endcase
   end

   // Datapath controls and result capture.
   always_comb begin
      count_in      = count_ff;
      op_in         = op_ff;
      wave_in       = '0;
      pull_seen_in  = pull_seen_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_urg_in    = res_urg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      ctl.shift_up  = 1'b0;
      ctl.fwd       = wave_ff;

      // drop the response once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (sts.pull_done) begin
         pull_seen_in = 1'b1;
      end

      unique case (state_ff)
         tcpq_pkg::CTL_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               pull_seen_in  = 1'b0;
               res_status_in = tcpq_pkg::STAT_OK;
               res_key_in    = '0;
               res_urg_in    = 1'b0;
               unique case (req_op)
                  tcpq_pkg::OP_ADD: begin
                     if (full) begin
                        res_status_in = tcpq_pkg::STAT_FULL;
                     end else begin
                        // launch the insert wave at the head slot
                        wave_in.act     = 1'b1;
                        wave_in.mode    = tcpq_pkg::WAVE_SEEK;
                        wave_in.ent.key = req_key;
                        wave_in.ent.urg = req_urg;
                     end
                  end
                  tcpq_pkg::OP_PROMOTE: begin
                     wave_in.act     = 1'b1;
                     wave_in.mode    = tcpq_pkg::WAVE_SEARCH;
                     wave_in.ent.key = req_key;
                     wave_in.ent.urg = 1'b0;
                  end
                  tcpq_pkg::OP_SERVE: begin
                     if (empty) begin
                        res_status_in = tcpq_pkg::STAT_EMPTY;
                     end else begin
                        // pop the head, advance every slot one place
                        ctl.shift_up = 1'b1;
                        res_key_in   = sts.head_ent.key;
                        res_urg_in   = sts.head_ent.urg;
                        count_in     = count_ff - tcpq_pkg::CNT_BITS'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcpq_pkg::CTL_WAVE: begin
            if (sts.tail_fwd.act) begin
               if (op_ff == tcpq_pkg::OP_ADD) begin
                  count_in = count_ff + tcpq_pkg::CNT_BITS'(1);
               end else if (sts.tail_fwd.mode != tcpq_pkg::WAVE_PASS) begin
                  // search wave left the tail without a hit
                  res_status_in = tcpq_pkg::STAT_NOT_FOUND;
               end
            end
         end
         tcpq_pkg::CTL_PULL: begin
         end
         tcpq_pkg::CTL_POST: begin
            if (post_ok) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = tcpq_pkg::RSP_TDATA_BITS'(
                  {tcpq_pkg::OCC_BITS'(count_ff), res_key_ff});
               rsp_tuser_in = {res_urg_ff, res_status_ff};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcpq_pkg::CTL_IDLE;
         count_ff     <= '0;
         wave_ff      <= '0;
         pull_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wave_ff      <= wave_in;
         pull_seen_ff <= pull_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_urg_ff    <= res_urg_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `TCPQ_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= tcpq_pkg::CNT_BITS'(tcpq_pkg::DEPTH))
   `TCPQ_ASSERT_IMPLY(a_tail_in_wave, clock, reset, sts.tail_fwd.act, state_ff == tcpq_pkg::CTL_WAVE)
   `TCPQ_ASSERT_IMPLY(a_pull_window, clock, reset, sts.pull_done, (state_ff == tcpq_pkg::CTL_WAVE) || (state_ff == tcpq_pkg::CTL_PULL))
   `TCPQ_ASSERT_NEXT(a_post_shows, clock, reset, (state_ff == tcpq_pkg::CTL_POST) && post_ok, rsp_tvalid)
   `TCPQ_ASSERT_NEXT(a_serve_count, clock, reset, ctl.shift_up, count_ff == ($past(count_ff) - tcpq_pkg::CNT_BITS'(1)))

endmodule

FILE: hdl/tcpq_cell.sv
`timescale 1ns / 1ps

// One queue slot: holds an entry and relays the tailward and headward waves.
module tcpq_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                head,
   input  logic                occupied,
   input  tcpq_pkg::entry_type up_ent,
   input  tcpq_pkg::entry_type dn_ent,
   input  logic                shift_up,
   input  tcpq_pkg::fwd_type   fwd_in,
   input  tcpq_pkg::bw_type    bw_in,
   output tcpq_pkg::entry_type ent_out,
   output tcpq_pkg::fwd_type   fwd_out,
   output tcpq_pkg::bw_type    bw_out,
   output logic                pull_done
);

   tcpq_pkg::entry_type ent_ff, ent_in;
   tcpq_pkg::fwd_type   fwd_ff, fwd_in_nx;
   tcpq_pkg::bw_type    bw_ff, bw_in_nx;
   logic                match;

   always_comb begin
      ent_in    = ent_ff;
      fwd_in_nx = fwd_in;
      bw_in_nx  = '0;
      match     = 1'b0;

      // serve: take the tail-side neighbor
      if (shift_up) begin
         ent_in = dn_ent;
      end

      if (fwd_in.act) begin
         unique case (fwd_in.mode)
            tcpq_pkg::WAVE_SEEK: begin
               if (!occupied || (fwd_in.ent.urg && !ent_ff.urg)) begin
                  ent_in         = fwd_in.ent;
                  fwd_in_nx.mode = occupied ? tcpq_pkg::WAVE_SHIFT : tcpq_pkg::WAVE_PASS;
                  fwd_in_nx.ent  = ent_ff;
               end
            end
            tcpq_pkg::WAVE_SHIFT: begin
               ent_in         = fwd_in.ent;
               fwd_in_nx.mode = occupied ? tcpq_pkg::WAVE_SHIFT : tcpq_pkg::WAVE_PASS;
               fwd_in_nx.ent  = ent_ff;
            end
            tcpq_pkg::WAVE_SEARCH: begin
               if (occupied && (ent_ff.key == fwd_in.ent.key)) begin
                  match          = 1'b1;
                  fwd_in_nx.mode = tcpq_pkg::WAVE_PASS;
                  if (!head) begin
                     ent_in       = up_ent;
                     bw_in_nx.act = 1'b1;
                     bw_in_nx.ent = ent_ff;
                  end
               end
            end
            tcpq_pkg::WAVE_PASS: begin
            end
         endcase
      end

      // promote pull: take the head-side neighbor, the head takes the carry
      if (bw_in.act) begin
         ent_in       = head ? bw_in.ent : up_ent;
         bw_in_nx.act = !head;
         bw_in_nx.ent = bw_in.ent;
      end

      pull_done = head && (bw_in.act || match);
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         bw_ff  <= '0;
      end else begin
         fwd_ff <= fwd_in_nx;
         bw_ff  <= bw_in_nx;
      end
   end

   assign ent_out = ent_ff;
   assign fwd_out = fwd_ff;
   assign bw_out  = bw_ff;

endmodule

FILE: hdl/tcpq_chain.sv
`timescale 1ns / 1ps

// Row of queue slots, head at index 0.
module tcpq_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcpq_pkg::CNT_BITS-1:0] count,
   input  tcpq_pkg::chain_ctl_type       ctl,
   output tcpq_pkg::chain_sts_type       sts
);

   tcpq_pkg::entry_type ent_w [tcpq_pkg::DEPTH];
   tcpq_pkg::entry_type up_w  [tcpq_pkg::DEPTH];
   tcpq_pkg::entry_type dn_w  [tcpq_pkg::DEPTH];
   tcpq_pkg::fwd_type   fwd_w [tcpq_pkg::DEPTH];
   tcpq_pkg::fwd_type   fwi_w [tcpq_pkg::DEPTH];
   tcpq_pkg::bw_type    bw_w  [tcpq_pkg::DEPTH];
   tcpq_pkg::bw_type    bwi_w [tcpq_pkg::DEPTH];
   logic                occ_w [tcpq_pkg::DEPTH];
   logic                pull_w[tcpq_pkg::DEPTH];

   for (genvar gi = 0; gi < tcpq_pkg::DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
         assign fwi_w[gi] = ctl.fwd;
         assign up_w[gi]  = '0;
      end else begin : g_body
         assign fwi_w[gi] = fwd_w[gi-1];
         assign up_w[gi]  = ent_w[gi-1];
      end

      if (gi == tcpq_pkg::DEPTH - 1) begin : g_tail
         assign dn_w[gi]  = '0;
         assign bwi_w[gi] = '0;
      end else begin : g_link
         assign dn_w[gi]  = ent_w[gi+1];
         assign bwi_w[gi] = bw_w[gi+1];
      end

      assign occ_w[gi] = (tcpq_pkg::CNT_BITS'(gi) < count);

      tcpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .head      (gi == 0),
         .occupied  (occ_w[gi]),
         .up_ent    (up_w[gi]),
         .dn_ent    (dn_w[gi]),
         .shift_up  (ctl.shift_up),
         .fwd_in    (fwi_w[gi]),
         .bw_in     (bwi_w[gi]),
         .ent_out   (ent_w[gi]),
         .fwd_out   (fwd_w[gi]),
         .bw_out    (bw_w[gi]),
         .pull_done (pull_w[gi])
      );
   end

   assign sts.pull_done = pull_w[0];
   assign sts.tail_fwd  = fwd_w[tcpq_pkg::DEPTH-1];
   assign sts.head_ent  = ent_w[0];

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import tcpq_pkg::*;

   // Operation code that the block must treat as a no-op.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   // Total number of request beats before the run winds down.
   localparam int ITEM_TOTAL = 1700;

   // Receiver hold-off long enough to back up the request side.
   localparam int HOLD_OFF_CYCLES = 400;

   // Drain time after the last response; covers the slowest promote.
   localparam int SETTLE_CYCLES = 2 * DEPTH + 50;

   typedef struct packed {
      logic [STS_BITS-1:0] status;
      logic [KEY_BITS-1:0] served_key;
      logic                served_urg;
      logic [OCC_BITS-1:0] occupancy;
   } response_type;

   // Shadow copy of the queue: predicts one response per request beat and
   // matches the responses in order.
   class queue_shadow;
      entry_type    slots[$];
      response_type expected_beats[$];
      int           mismatches;

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function int occupancy();
         return slots.size();
      endfunction

      function logic [KEY_BITS-1:0] key_at(int idx);
         return slots[idx].key;
      endfunction

      function int outstanding();
         return expected_beats.size();
      endfunction

      function void note_request(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                                 logic urg);
         response_type beat;
         entry_type    ent;
         int           pos;
         beat = '0;
         beat.status = STAT_OK;
         case (op)
            OP_ADD: begin
               if (slots.size() >= DEPTH) begin
                  beat.status = STAT_FULL;
               end else if (urg) begin
                  // Slot in behind the urgent run at the head.
                  pos = 0;
                  while (pos < slots.size() && slots[pos].urg) begin
                     pos++;
                  end
                  ent.key = key;
                  ent.urg = 1'b1;
                  slots.insert(pos, ent);
               end else begin
                  ent.key = key;
                  ent.urg = 1'b0;
                  slots.push_back(ent);
               end
            end
            OP_PROMOTE: begin
               // Only the occurrence nearest the head moves; class is kept.
               pos = 0;
               while (pos < slots.size() && slots[pos].key != key) begin
                  pos++;
               end
               if (pos == slots.size()) begin
                  beat.status = STAT_NOT_FOUND;
               end else begin
                  ent = slots[pos];
                  slots.delete(pos);
                  slots.push_front(ent);
               end
            end
            OP_SERVE: begin
               if (slots.size() == 0) begin
                  beat.status = STAT_EMPTY;
               end else begin
                  ent = slots.pop_front();
                  beat.served_key = ent.key;
                  beat.served_urg = ent.urg;
               end
            end
            default: begin
               // Unused code: state untouched, plain ok beat.
            end
         endcase
         beat.occupancy = OCC_BITS'(slots.size());
         expected_beats.push_back(beat);
      endfunction

      task check_response(response_type got);
         response_type want;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat status=%0d key=%h urg=%0d occ=%0d",
                             got.status, got.served_key, got.served_urg, got.occupancy));
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.served_key !== want.served_key)
            report($sformatf("served_key %h, want %h", got.served_key, want.served_key));
         if (got.served_urg !== want.served_urg)
            report($sformatf("served_urgent %0d, want %0d", got.served_urg, want.served_urg));
         if (got.occupancy !== want.occupancy)
            report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;   // key[15:0]
   logic [REQ_TUSER_BITS-1:0] req_tuser;   // operation[1:0], urgent[2]
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;   // served_key[15:0], occupancy[23:16]
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;   // status[1:0], served_urgent[2]

   queue_shadow shadow = new;

   bit sender_idles;
   bit receiver_idles;
   bit hold_off_request;
   int items_sent;

   two_class_priority_queue_promote_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_gap();
      if (!sender_idles || $urandom_range(0, 3) != 0)
         return 0;
      return $urandom_range(1, 14);
   endfunction

   function automatic logic pick_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Mostly a small pool so duplicates and promote hits are common.
   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0, 1:    return KEY_BITS'($urandom_range(0, 31));
         2:       return KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
         default: return $urandom_range(0, 1) ? {KEY_BITS{1'b1}} : {KEY_BITS{1'b0}};
      endcase
   endfunction

   // Favor keys that are queued right now, at any depth.
   function automatic logic [KEY_BITS-1:0] pick_promote_key();
      if (shadow.occupancy() > 0 && $urandom_range(0, 9) < 7)
         return shadow.key_at($urandom_range(0, shadow.occupancy() - 1));
      return pick_key();
   endfunction

   // Offer one request beat and hold it until accepted; valid stays high
   // into the next call when no gap follows.
   task automatic send_request(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                               logic urg);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(key);
      req_tuser  <= {urg, op};
      do @(posedge clock); while (!req_tready);
      shadow.note_request(op, key, urg);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_item(int add_pct, int serve_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2)
         send_request(OP_UNUSED, pick_key(), pick_bit());
      else if (pick < 2 + add_pct)
         send_request(OP_ADD, pick_key(), pick_bit());
      else if (pick < 2 + add_pct + serve_pct)
         send_request(OP_SERVE, pick_key(), pick_bit());
      else
         send_request(OP_PROMOTE, pick_promote_key(), pick_bit());
   endtask

   // Drop valid and hold until every predicted beat has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // Response side: check each accepted beat, then pick ready for the next
   // cycle from the stall counter, random bursts or a requested hold-off.
   initial begin
      int           stall_left;
      response_type got;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tuser[STS_BITS-1:0];
            got.served_urg = rsp_tuser[STS_BITS];
            got.served_key = rsp_tdata[KEY_BITS-1:0];
            got.occupancy  = rsp_tdata[KEY_BITS +: OCC_BITS];
            shadow.check_response(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (reset || stall_left > 0) begin
            rsp_tready <= 1'b0;
            if (stall_left > 0)
               stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int add_pct;
      int serve_pct;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      hold_off_request = 1'b0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: error cases on an empty queue, then class ordering.
      send_request(OP_SERVE, 16'h0000, 1'b0);
      send_request(OP_PROMOTE, 16'h0000, 1'b0);
      send_request(OP_UNUSED, 16'h0000, 1'b0);
      send_request(OP_ADD, 16'hFFFF, 1'b0);
      send_request(OP_ADD, 16'h0000, 1'b0);
      send_request(OP_ADD, 16'h1234, 1'b1);
      send_request(OP_ADD, 16'h5678, 1'b1);
      // Normal entry to the head empties the urgent run; next urgent add
      // must land at the head.
      send_request(OP_PROMOTE, 16'h0000, 1'b1);
      send_request(OP_ADD, 16'hAAAA, 1'b1);
      // Duplicate key: only the copy nearest the head moves.
      send_request(OP_ADD, 16'h1234, 1'b0);
      send_request(OP_PROMOTE, 16'h1234, 1'b0);
      send_request(OP_PROMOTE, 16'h4321, 1'b1);
      send_request(OP_PROMOTE, 16'hFFFF, 1'b0);
      send_request(OP_UNUSED, 16'hFFFF, 1'b1);
      repeat (4) send_request(OP_SERVE, 16'hFFFF, 1'b1);
      send_request(OP_SERVE, 16'h0000, 1'b0);
      send_request(OP_SERVE, 16'h0000, 1'b0);

      // Long receiver hold-off while requests keep coming.
      hold_off_request = 1'b1;
      repeat (20) send_random_item(50, 20);
      wait_drained();

      // Fill to the brim, push past full, promote from deep slots, drain.
      while (shadow.occupancy() < DEPTH)
         send_random_item(85, 5);
      repeat (3) send_request(OP_ADD, pick_key(), pick_bit());
      send_request(OP_PROMOTE, shadow.key_at(DEPTH - 1), 1'b0);
      send_request(OP_PROMOTE, shadow.key_at(DEPTH / 2), 1'b1);
      send_request(OP_ADD, pick_key(), 1'b1);
      while (shadow.occupancy() > 0)
         send_random_item(5, 80);
      repeat (2) send_request(OP_SERVE, pick_key(), pick_bit());
      wait_drained();

      // Random rounds with shifting mix; the tail runs without idling.
      while (items_sent < ITEM_TOTAL) begin
         if (ITEM_TOTAL - items_sent <= 200) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end else begin
            sender_idles = $urandom_range(0, 2) != 0;
            receiver_idles = $urandom_range(0, 2) != 0;
         end
         case ($urandom_range(0, 2))
            0: begin
               add_pct = 60;
               serve_pct = 18;
            end
            1: begin
               add_pct = 25;
               serve_pct = 55;
            end
            default: begin
               add_pct = 40;
               serve_pct = 30;
            end
         endcase
         repeat (100) send_random_item(add_pct, serve_pct);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
